// ----- design/sva_pkg.sv -----
// sva_pkg: types and constants shared by the voice allocator modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sva_pkg;
   localparam int VOICES_DEF = 18;
   localparam int CHANNELS_DEF = 16;
   localparam logic [28:0] AGE_MASK = 29'h1fffffff;
   localparam logic [6:0] HOLD_LEVEL = 7'h40;
   localparam logic [6:0] PERC_LOW = 7'd35;
   localparam logic [6:0] PERC_HIGH = 7'd81;

   typedef enum logic [2:0] {
      CMD_NOTE_ON = 3'd0, CMD_NOTE_OFF = 3'd1, CMD_SUSTAIN = 3'd2, CMD_NOTES_OFF = 3'd3,
      CMD_SOUNDS_OFF = 3'd4, CMD_STOP_ALL = 3'd5, CMD_RESET_CH = 3'd6, CMD_TOUCH = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_ON_PRI = 2'd0, ACT_ON_SEC = 2'd1, ACT_OFF = 2'd2, ACT_KILL = 2'd3
   } act_type;

   localparam logic [1:0] REG_VOICES = 2'd0;
   localparam logic [1:0] REG_PERC = 2'd1;
   localparam logic [1:0] REG_SINGLE = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [3:0]  midi_channel;
      logic [6:0]  note_number;
      logic [6:0]  event_value;
      logic        double_voice;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [4:0] voice;
      logic [1:0] action;
      logic [3:0] owner_channel;
      logic [6:0] voice_note;
      logic       last;
   } rsp_type;

   // one voice entry as held in memory
   typedef struct packed {
      logic [3:0]  owner;
      logic        free;
      logic [6:0]  note;
      logic        sustained;
      logic        secondary;
      logic [28:0] stamp;
   } voice_type;
endpackage
`default_nettype wire

// ----- design/synth_voice_allocator_top.sv -----
// synth_voice_allocator_top: voice allocator, sequencer over the voice memory
// depends on sva_pkg, sva_ram
//
//  channel | direction | handshake        | payload
//  req_    | in        | valid / stall    | sva_pkg::req_type
//  rsp_    | out       | valid / stall    | sva_pkg::rsp_type
//  csr_    | in        | write enable     | index, 6-bit data
//
// one transaction at a time: the request is accepted, then decoded, and held results
// are flushed at the end; each pass reads the n scanned voices, one memory read a
// cycle while no result is stalled; note-on needs up to two passes, each followed by
// S_PICK, S_OCC_WT and S_OCC to take the chosen voice
// each result stalls the pass until rsp_stall lets it go
// after reset a clearing pass zeroes the voice memory; the pedals are reset registers
`timescale 1ns / 1ps
`default_nettype none
module synth_voice_allocator_top #(
   parameter int VOICES = sva_pkg::VOICES_DEF,
   parameter int MIDI_CHANNELS = sva_pkg::CHANNELS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sva_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sva_pkg::rsp_type       rsp_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [5:0]        csr_data
);
   import sva_pkg::*;

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int VW1 = $clog2(VOICES + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_WAIT, S_PICK, S_OCC_RD, S_OCC_WT, S_OCC,
      S_DONE
   } state_type;

   state_type state_ff;
   req_type   req_ff;
   logic [5:0] nvoices_ff;
   logic [3:0] perc_ff;
   logic       single_ff;
   logic [6:0] pedal_ff [16];

   // scan bookkeeping
   logic [VW1-1:0] idx_ff;       // address issued
   logic           rdv_ff;       // read data valid this cycle
   logic [VW-1:0]  rdaddr_ff;    // address of read data
   logic [1:0]     phase_ff;     // 0 release/touch pass, 1 first pick, 2 second pick
   logic [31:0]    best_ff;
   logic [VW-1:0]  bv_ff;
   logic           pend_ff;      // result held waiting for more
   rsp_type        pend_data_ff;
   logic           out_v_ff;
   rsp_type        out_d_ff;

   // memory port
   logic           wr_en;
   logic [VW-1:0]  wr_addr, rd_addr;
   voice_type      wr_data, rd_data;

   sva_ram #(.WIDTH($bits(voice_type)), .DEPTH(VOICES)) u_voice_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [VW1-1:0] n_scan;
   assign n_scan = ({1'b0, nvoices_ff} > 7'(VOICES)) ? VW1'(VOICES) : VW1'(nvoices_ff);

   logic [6:0] ch_pedal;
   assign ch_pedal = (32'(req_ff.midi_channel) < MIDI_CHANNELS) ?
                     pedal_ff[req_ff.midi_channel] : 7'd0;
   logic hold;
   assign hold = ch_pedal >= HOLD_LEVEL;

   // per-entry decision on the read data
   logic owned, same;
   assign owned = !rd_data.free && rd_data.owner == req_ff.midi_channel;
   assign same  = owned && rd_data.note == req_ff.note_number;
   logic [31:0] score;
   always_comb begin
      score = {3'b000, 29'(req_ff.now[28:0] - rd_data.stamp)};
      score[31] = rd_data.free;
      score[30] = same;
      score[29] = rd_data.sustained;
   end

   logic       is_off, emit_rel, kill_rel, set_sust, touch;
   always_comb begin
      is_off = (req_ff.command == CMD_NOTE_OFF) ||
               (req_ff.command == CMD_NOTE_ON && req_ff.event_value == 7'd0);
      emit_rel = 1'b0; kill_rel = 1'b0; set_sust = 1'b0; touch = 1'b0;
      if (is_off) begin
         if (same) begin
            if (hold) set_sust = 1'b1;
            else emit_rel = 1'b1;
         end
      end else begin
         case (req_ff.command)
            CMD_SUSTAIN: emit_rel = req_ff.event_value < HOLD_LEVEL && owned &&
                                    rd_data.sustained;
            CMD_NOTES_OFF: begin
               if (owned) begin
                  if (hold) set_sust = 1'b1;
                  else emit_rel = 1'b1;
               end
            end
            CMD_SOUNDS_OFF: emit_rel = owned;
            CMD_STOP_ALL: begin
               emit_rel = !rd_data.free;
               kill_rel = 1'b1;
            end
            CMD_TOUCH: touch = owned;
            default: ;
         endcase
      end
   end

   logic out_free;
   assign out_free = !out_v_ff || !rsp_stall;
   // a new result can be queued when the pending slot is empty or moves out now
   logic can_push;
   assign can_push = !pend_ff || out_free;

   logic perc_skip;
   assign perc_skip = req_ff.midi_channel == perc_ff &&
                      (req_ff.note_number < PERC_LOW || req_ff.note_number > PERC_HIGH);

   logic [VW-1:0] clr_ff;
   logic          scan_step;

   // held result leaves with last set at the end of the transaction
   logic flush;
   assign flush = state_ff == S_DONE && pend_ff && out_free;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_d_ff;

   // combinational memory control and push
   logic     push;
   rsp_type  push_d;
   always_comb begin
      wr_en = 1'b0; wr_addr = rdaddr_ff; wr_data = rd_data;
      rd_addr = idx_ff[VW-1:0];
      push = 1'b0; push_d = '0;
      scan_step = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1; wr_addr = clr_ff; wr_data = '0;
         end
         S_SCAN, S_WAIT: begin
            scan_step = can_push;
            // a stalled step keeps the entry under work on the read port
            rd_addr = can_push ? idx_ff[VW-1:0] : rdaddr_ff;
            if (rdv_ff && phase_ff == 2'd0 && can_push) begin
               if (emit_rel) begin
                  push = 1'b1;
                  push_d.voice = 5'(rdaddr_ff);
                  push_d.action = kill_rel ? ACT_KILL : ACT_OFF;
                  push_d.owner_channel = rd_data.owner;
                  push_d.voice_note = rd_data.note;
                  wr_en = 1'b1;
                  wr_data.free = 1'b1;
                  wr_data.stamp = req_ff.now[28:0];
                  wr_data.sustained = 1'b0;
                  wr_data.secondary = 1'b0;
               end else if (set_sust) begin
                  wr_en = 1'b1; wr_data.sustained = 1'b1;
               end else if (touch) begin
                  wr_en = 1'b1; wr_data.stamp = req_ff.now[28:0];
               end
            end
         end
         S_OCC_WT: rd_addr = bv_ff;
         S_OCC: begin
            rd_addr = bv_ff;
            // kill, then key on; the two results are pushed in turn, selected by idx_ff[0]
            if (can_push) begin
               push = 1'b1;
               push_d.voice = 5'(bv_ff);
               if (!idx_ff[0]) begin
                  push_d.action = ACT_KILL;
                  push_d.owner_channel = rd_data.owner;
                  push_d.voice_note = rd_data.note;
               end else begin
                  push_d.action = (phase_ff == 2'd2) ? ACT_ON_SEC : ACT_ON_PRI;
                  push_d.owner_channel = req_ff.midi_channel;
                  push_d.voice_note = req_ff.note_number;
                  wr_en = 1'b1; wr_addr = bv_ff;
                  wr_data.owner = req_ff.midi_channel;
                  wr_data.note = req_ff.note_number;
                  wr_data.free = 1'b0;
                  wr_data.sustained = 1'b0;
                  wr_data.secondary = phase_ff == 2'd2;
                  wr_data.stamp = req_ff.now[28:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         nvoices_ff <= 6'd9; perc_ff <= 4'd15; single_ff <= 1'b0;
         for (int c = 0; c < 16; c++) pedal_ff[c] <= 7'd0;
         out_v_ff <= 1'b0; pend_ff <= 1'b0; rdv_ff <= 1'b0;
         idx_ff <= '0; phase_ff <= 2'd0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_VOICES: nvoices_ff <= csr_data;
               REG_PERC:   perc_ff <= csr_data[3:0];
               REG_SINGLE: single_ff <= csr_data[0];
               default: ;
            endcase
         end
         // output staging: pending result goes out when next arrives or at end
         if (push && pend_ff) begin
            out_v_ff <= 1'b1; out_d_ff <= pend_data_ff;
         end else if (flush) begin
            out_v_ff <= 1'b1;
            out_d_ff <= '{voice: pend_data_ff.voice, action: pend_data_ff.action,
                          owner_channel: pend_data_ff.owner_channel,
                          voice_note: pend_data_ff.voice_note, last: 1'b1};
         end else if (out_free) out_v_ff <= 1'b0;
         if (push) begin
            pend_ff <= 1'b1; pend_data_ff <= push_d;
         end else if (flush) pend_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == VOICES - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               idx_ff <= '0; rdv_ff <= 1'b0;
               best_ff <= '0; bv_ff <= '0;
               if (req_ff.command == CMD_SUSTAIN &&
                   32'(req_ff.midi_channel) < MIDI_CHANNELS)
                  pedal_ff[req_ff.midi_channel] <= req_ff.event_value;
               if (req_ff.command == CMD_RESET_CH &&
                   32'(req_ff.midi_channel) < MIDI_CHANNELS)
                  pedal_ff[req_ff.midi_channel] <= 7'd0;
               if (req_ff.command == CMD_NOTE_ON && req_ff.event_value != 7'd0) begin
                  phase_ff <= 2'd1;
                  state_ff <= perc_skip ? S_DONE : S_SCAN;
               end else begin
                  phase_ff <= 2'd0;
                  state_ff <= (req_ff.command == CMD_RESET_CH) ? S_DONE : S_SCAN;
               end
            end
            S_SCAN, S_WAIT: begin
               if (scan_step) begin
                  if (rdv_ff && phase_ff != 2'd0 && score > best_ff) begin
                     best_ff <= score; bv_ff <= rdaddr_ff;
                  end
                  if (state_ff == S_SCAN && idx_ff < n_scan) begin
                     rdv_ff <= 1'b1; rdaddr_ff <= idx_ff[VW-1:0];
                     idx_ff <= idx_ff + 1'b1;
                  end else begin
                     rdv_ff <= 1'b0;
                     if (state_ff == S_WAIT || !rdv_ff)
                        state_ff <= (phase_ff == 2'd0) ? S_DONE : S_PICK;
                     else state_ff <= S_WAIT;
                  end
               end
            end
            S_PICK: begin
               idx_ff <= '0;
               if (phase_ff == 2'd2 && !best_ff[31]) state_ff <= S_DONE;
               else state_ff <= S_OCC_WT;
            end
            S_OCC_WT: state_ff <= S_OCC;
            S_OCC: begin
               if (can_push) begin
                  if (!idx_ff[0]) idx_ff <= VW1'(1);
                  else begin
                     idx_ff <= '0; rdv_ff <= 1'b0; best_ff <= '0; bv_ff <= '0;
                     if (phase_ff == 2'd1 && req_ff.double_voice && !single_ff &&
                         n_scan != '0) begin
                        phase_ff <= 2'd2; state_ff <= S_SCAN;
                     end else state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               if (!pend_ff || flush) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- design/sva_ram.sv -----
// sva_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- tb/sv/synth_voice_allocator_top_tb.sv -----
// synth_voice_allocator_top_tb: self-checking bench for the voice allocator
// depends on sva_pkg and synth_voice_allocator_top; keeps its own voice table
// and predicts key-on, key-off and kill transactions in order
`timescale 1ns / 1ps
module synth_voice_allocator_top_tb;
   import sva_pkg::*;

   localparam int NV = VOICES_DEF;
   localparam int NCH = CHANNELS_DEF;
   localparam int SETTLE = 4 * (NV + 2) + 20;
   localparam int WATCHDOG = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = REG_VOICES;
   logic [5:0] csr_data = '0;

   synth_voice_allocator_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // mirror of the voice table and channel pedals
   logic [3:0]  v_owner [NV];
   logic        v_free [NV];
   logic [6:0]  v_note [NV];
   logic        v_sust [NV];
   logic        v_sec [NV];
   logic [28:0] v_stamp [NV];
   logic [6:0]  ch_pedal [NCH];
   logic [5:0]  cfg_voices;
   logic [3:0]  cfg_perc;
   logic        cfg_single;

   req_type pending_q[$];
   rsp_type voice_events_q[$];
   int errors = 0;
   int accepted_reqs = 0;
   int checked_events = 0;
   int idle_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int scan_len();
      return (cfg_voices > NV) ? NV : int'(cfg_voices);
   endfunction

   function automatic bit owns(int i, logic [3:0] ch);
      return !v_free[i] && v_owner[i] == ch;
   endfunction

   function automatic void push_event(int i, act_type act, logic [3:0] ch, logic [6:0] nt);
      rsp_type e;
      e.voice = i[4:0];
      e.action = act;
      e.owner_channel = ch;
      e.voice_note = nt;
      e.last = 1'b0;
      voice_events_q.push_back(e);
   endfunction

   function automatic void free_voice(int i, bit kill, logic [31:0] t);
      push_event(i, kill ? ACT_KILL : ACT_OFF, v_owner[i], v_note[i]);
      v_free[i] = 1'b1;
      v_stamp[i] = t[28:0];
      v_sust[i] = 1'b0;
      v_sec[i] = 1'b0;
   endfunction

   // highest score wins: free, same channel and note, sustained, then age
   function automatic int best_voice(logic [3:0] ch, logic [6:0] nt, logic [31:0] t,
                                     bit need_free);
      logic [31:0] s, best;
      int bv;
      best = '0;
      bv = 0;
      for (int i = 0; i < scan_len(); i++) begin
         s = (t - {3'b000, v_stamp[i]}) & 32'h1fffffff;
         if (v_free[i]) s[31] = 1'b1;
         if (owns(i, ch) && v_note[i] == nt) s[30] = 1'b1;
         if (v_sust[i]) s[29] = 1'b1;
         if (s > best) begin
            best = s;
            bv = i;
         end
      end
      if (need_free && !best[31]) return -1;
      return bv;
   endfunction

   function automatic void take_voice(int i, logic [3:0] ch, logic [6:0] nt, bit sec,
                                      logic [31:0] t);
      free_voice(i, 1'b1, t);
      v_owner[i] = ch;
      v_note[i] = nt;
      v_free[i] = 1'b0;
      v_sust[i] = 1'b0;
      v_sec[i] = sec;
      v_stamp[i] = t[28:0];
      push_event(i, sec ? ACT_ON_SEC : ACT_ON_PRI, ch, nt);
   endfunction

   function automatic void release_note(logic [3:0] ch, logic [6:0] nt, logic [31:0] t);
      bit hold;
      hold = ch_pedal[ch] >= HOLD_LEVEL;
      for (int i = 0; i < scan_len(); i++)
         if (owns(i, ch) && v_note[i] == nt) begin
            if (hold) v_sust[i] = 1'b1;
            else free_voice(i, 1'b0, t);
         end
   endfunction

   function automatic void predict_events(req_type r);
      int before_n, v;
      before_n = voice_events_q.size();
      case (cmd_type'(r.command))
         CMD_NOTE_ON: begin
            if (r.event_value == 0) release_note(r.midi_channel, r.note_number, r.now);
            else if (!(r.midi_channel == cfg_perc &&
                       (r.note_number < PERC_LOW || r.note_number > PERC_HIGH))) begin
               v = best_voice(r.midi_channel, r.note_number, r.now, 1'b0);
               take_voice(v, r.midi_channel, r.note_number, 1'b0, r.now);
               if (r.double_voice && !cfg_single) begin
                  v = best_voice(r.midi_channel, r.note_number, r.now, 1'b1);
                  if (v >= 0) take_voice(v, r.midi_channel, r.note_number, 1'b1, r.now);
               end
            end
         end
         CMD_NOTE_OFF: release_note(r.midi_channel, r.note_number, r.now);
         CMD_SUSTAIN: begin
            ch_pedal[r.midi_channel] = r.event_value;
            if (r.event_value < HOLD_LEVEL)
               for (int i = 0; i < scan_len(); i++)
                  if (owns(i, r.midi_channel) && v_sust[i]) free_voice(i, 1'b0, r.now);
         end
         CMD_NOTES_OFF: begin
            for (int i = 0; i < scan_len(); i++)
               if (owns(i, r.midi_channel)) begin
                  if (ch_pedal[r.midi_channel] < HOLD_LEVEL) free_voice(i, 1'b0, r.now);
                  else v_sust[i] = 1'b1;
               end
         end
         CMD_SOUNDS_OFF: begin
            for (int i = 0; i < scan_len(); i++)
               if (owns(i, r.midi_channel)) free_voice(i, 1'b0, r.now);
         end
         CMD_STOP_ALL: begin
            for (int i = 0; i < scan_len(); i++)
               if (!v_free[i]) free_voice(i, 1'b1, r.now);
         end
         CMD_RESET_CH: ch_pedal[r.midi_channel] = '0;
         default: begin
            for (int i = 0; i < scan_len(); i++)
               if (owns(i, r.midi_channel)) v_stamp[i] = r.now[28:0];
         end
      endcase
      if (voice_events_q.size() > before_n)
         voice_events_q[voice_events_q.size() - 1].last = 1'b1;
   endfunction

   // sender: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_events(req_data);
            accepted_reqs <= accepted_reqs + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_data <= pending_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 10);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern switches between modes, plus one long hold-off
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_reqs >= 60) begin
         hold_left <= 400;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 120);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (voice_events_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, rsp_data);
            errors <= errors + 1;
         end else begin
            e = voice_events_q.pop_front();
            checked_events <= checked_events + 1;
            if (rsp_data.voice !== e.voice || rsp_data.action !== e.action ||
                rsp_data.owner_channel !== e.owner_channel ||
                rsp_data.voice_note !== e.voice_note || rsp_data.last !== e.last) begin
               $display("%0t: mismatch voice/action/chan/note/last expected %0d %0d %0d %0d %0d actual %0d %0d %0d %0d %0d",
                        $time, e.voice, e.action, e.owner_channel, e.voice_note, e.last,
                        rsp_data.voice, rsp_data.action, rsp_data.owner_channel,
                        rsp_data.voice_note, rsp_data.last);
               errors <= errors + 1;
            end
         end
      end
   end

   // watchdog on cycles with nothing accepted on any port
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG) begin
         $display("%0t: timeout, %0d transactions still expected", $time,
                  voice_events_q.size());
         $display("TEST FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic req_type note_event(cmd_type c, logic [3:0] ch, logic [6:0] nt,
                                          logic [6:0] val, logic dbl, logic [31:0] t);
      req_type r;
      r.command = c;
      r.midi_channel = ch;
      r.note_number = nt;
      r.event_value = val;
      r.double_voice = dbl;
      r.now = t;
      return r;
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (pending_q.size() > 0 || req_valid || voice_events_q.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [5:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == REG_VOICES) cfg_voices = val;
      else if (idx == REG_PERC) cfg_perc = val[3:0];
      else if (idx == REG_SINGLE) cfg_single = val[0];
   endtask

   logic [31:0] clock_now = 32'd1000;

   function automatic req_type random_event();
      logic [3:0] ch;
      logic [6:0] nt, val;
      int pick;
      if ($urandom_range(0, 9) == 0) clock_now = $urandom;
      else clock_now = clock_now + $urandom_range(0, 3000);
      ch = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
      nt = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(34, 42));
      val = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) return note_event(CMD_NOTE_ON, ch, nt, val, 1'($urandom), clock_now);
      if (pick < 65) return note_event(CMD_NOTE_OFF, ch, nt, val, 1'($urandom), clock_now);
      if (pick < 75) return note_event(CMD_SUSTAIN, ch, nt,
                                       $urandom_range(0, 1) ? 7'd127 : val, 1'($urandom),
                                       clock_now);
      return note_event(cmd_type'($urandom_range(3, 7)), ch, nt, val, 1'($urandom), clock_now);
   endfunction

   initial begin
      logic [5:0] voice_set [6] = '{6'd18, 6'd32, 6'd1, 6'd0, 6'd63, 6'd5};
      logic [3:0] perc_set [6] = '{4'd9, 4'd0, 4'd15, 4'd3, 4'd1, 4'd15};
      logic       single_set [6] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
      for (int i = 0; i < NV; i++) begin
         v_owner[i] = '0; v_free[i] = 1'b0; v_note[i] = '0;
         v_sust[i] = 1'b0; v_sec[i] = 1'b0; v_stamp[i] = '0;
      end
      for (int c = 0; c < NCH; c++) ch_pedal[c] = '0;
      cfg_voices = 6'd9;
      cfg_perc = 4'd15;
      cfg_single = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (NV + 4) @(posedge clock);

      // directed: reset state, percussion range, pedal hold, every command, extremes
      @(negedge clock);
      pending_q.push_back(note_event(CMD_TOUCH, 4'd0, 7'd0, 7'd0, 1'b0, 32'd0));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd0, 7'd0, 7'd127, 1'b1, 32'd5));
      pending_q.push_back(note_event(CMD_NOTE_OFF, 4'd0, 7'd0, 7'd0, 1'b0, 32'd9));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd15, 7'd34, 7'd100, 1'b0, 32'd20));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd15, 7'd82, 7'd100, 1'b0, 32'd21));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd15, 7'd35, 7'd1, 1'b1, 32'd22));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd15, 7'd81, 7'd64, 1'b1, 32'd23));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd3, 7'd127, 7'd90, 1'b1, 32'hffffffff));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd3, 7'd127, 7'd0, 1'b0, 32'h80000000));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd2, 7'd60, 7'd80, 1'b0, 32'h20000000));
      pending_q.push_back(note_event(CMD_SUSTAIN, 4'd2, 7'd0, 7'd64, 1'b0, 32'h20000010));
      pending_q.push_back(note_event(CMD_NOTE_OFF, 4'd2, 7'd60, 7'd0, 1'b0, 32'h20000020));
      pending_q.push_back(note_event(CMD_NOTES_OFF, 4'd2, 7'd0, 7'd0, 1'b0, 32'h20000030));
      pending_q.push_back(note_event(CMD_SUSTAIN, 4'd2, 7'd0, 7'd63, 1'b0, 32'h20000040));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd2, 7'd61, 7'd80, 1'b1, 32'h20000050));
      pending_q.push_back(note_event(CMD_SUSTAIN, 4'd2, 7'd0, 7'd127, 1'b0, 32'h20000060));
      pending_q.push_back(note_event(CMD_RESET_CH, 4'd2, 7'd0, 7'd0, 1'b0, 32'h20000070));
      pending_q.push_back(note_event(CMD_NOTES_OFF, 4'd2, 7'd0, 7'd0, 1'b0, 32'h20000080));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd5, 7'd40, 7'd10, 1'b0, 32'h30000000));
      pending_q.push_back(note_event(CMD_TOUCH, 4'd5, 7'd0, 7'd0, 1'b0, 32'h3fffffff));
      pending_q.push_back(note_event(CMD_SOUNDS_OFF, 4'd5, 7'd0, 7'd0, 1'b0, 32'h40000000));
      pending_q.push_back(note_event(CMD_NOTE_ON, 4'd6, 7'd50, 7'd127, 1'b1, 32'h40000100));
      pending_q.push_back(note_event(CMD_STOP_ALL, 4'd9, 7'd0, 7'd0, 1'b0, 32'h40000200));
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_reg(REG_VOICES, voice_set[p]);
         write_reg(REG_PERC, {2'b00, perc_set[p]});
         write_reg(REG_SINGLE, {5'b0, single_set[p]});
         @(negedge clock);
         // a stop-all now and then keeps free voices around
         for (int k = 0; k < 24; k++) begin
            if ($urandom_range(0, 11) == 0)
               pending_q.push_back(note_event(CMD_STOP_ALL, 4'($urandom), 7'd0, 7'd0,
                                              1'b0, clock_now));
            else
               pending_q.push_back(random_event());
         end
         wait_drained();
      end

      $display("covered %0d requests and %0d voice events over 7 register settings",
               accepted_reqs, checked_events);
      $display("register extremes: 0, 1, 18, 32 and 63 voices, percussion 0..15, single 0/1");
      if (errors == 0 && voice_events_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ----- synth_voice_allocator_top.f -----
design/sva_pkg.sv
design/sva_ram.sv
design/synth_voice_allocator_top.sv
tb/sv/synth_voice_allocator_top_tb.sv
